// File: rtl/crcfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfb_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame builder.
// ----------------------------------------------------------------------------
package crcfb_pkg;

  localparam int CHAN_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 16;
  localparam int FRAME_BYTES = 10;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // Byte positions within a frame
  localparam logic [IDX_W-1:0] IDX_FIRST   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd8;
  localparam logic [IDX_W-1:0] IDX_CRC_HI  = 4'd9;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_one;
    logic [CHAN_W-1:0] channel_two;
    logic [CHAN_W-1:0] channel_three;
    logic [CHAN_W-1:0] channel_four;
  } crcfb_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_of_frame;
  } crcfb_out_t;

  // Head of the queue as seen by the back end
  typedef struct packed {
    logic      valid;
    crcfb_in_t data;
  } crcfb_head_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: rtl/crcfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfb_queue
// Front end: accepts channel transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module crcfb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  crcfb_pkg::crcfb_in_t item,
  output crcfb_pkg::crcfb_head_t head,
  input  logic                 pop
);
  import crcfb_pkg::*;

  crcfb_in_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              do_pop;

  assign ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign push   = valid && ready;
  assign do_pop = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid) else $error("pop from empty queue");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> count == $past(count) + 1'b1) else $error("count not advanced");

endmodule

// File: rtl/crcfb_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfb_serializer
// Back end: walks the head item out byte by byte, folding each data byte
// into the running CRC, then appends CRC low and high bytes.
// ----------------------------------------------------------------------------
module crcfb_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  crcfb_pkg::crcfb_head_t head,
  output logic                   pop,
  output logic                   valid,
  input  logic                   ready,
  output crcfb_pkg::crcfb_out_t  result
);
  import crcfb_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  crc_next;
  logic [CHAN_W-1:0] chan;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] cur_byte;
  logic              advance;
  logic              emit;

  assign advance = !valid || ready;
  assign emit    = advance && head.valid;
  assign pop     = emit && (idx == IDX_CRC_HI);

  always_comb begin
    unique case (idx[2:1])
      2'd0:    chan = head.data.channel_one;
      2'd1:    chan = head.data.channel_two;
      2'd2:    chan = head.data.channel_three;
      default: chan = head.data.channel_four;
    endcase
    data_byte = idx[0] ? chan[CHAN_W-1:BYTE_W] : chan[BYTE_W-1:0];
  end

  always_comb begin
    priority if (idx == IDX_CRC_LO) begin
      cur_byte = crc[BYTE_W-1:0];
    end else if (idx == IDX_CRC_HI) begin
      cur_byte = crc[CRC_W-1:BYTE_W];
    end else begin
      cur_byte = data_byte;
    end
  end

  always_comb begin
    idx_next = idx;
    crc_next = crc;
    if (emit) begin
      if (idx == IDX_CRC_HI) begin
        idx_next = IDX_FIRST;
        crc_next = CRC_INIT;
      end else begin
        idx_next = idx + 1'b1;
        if (idx < IDX_CRC_LO) crc_next = crc_update(crc, data_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= IDX_FIRST;
      crc   <= CRC_INIT;
      valid <= 1'b0;
    end else begin
      idx <= idx_next;
      crc <= crc_next;
      if (advance) valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.frame_byte    <= cur_byte;
      result.last_of_frame <= (idx == IDX_CRC_HI);
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_CRC_HI) else $error("byte index out of range");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (valid && result.last_of_frame) |-> (idx == IDX_FIRST))
    else $error("index not wrapped after last byte");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (idx != IDX_FIRST) |-> head.valid) else $error("head lost mid-frame");

endmodule

// File: rtl/four_channel_crc_frame_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_crc_frame_builder_top
// Four 16-bit channels in, ten-byte frame with CRC-16/MODBUS out.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into a queue entry, then its first byte
// is registered at the output. One byte per cycle while result_ready is high;
// the queue takes the next item mid-frame, so queued frames run back to back.
// Reset: synchronous, clears the queue, byte index, CRC and output valid.
module four_channel_crc_frame_builder_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  crcfb_pkg::crcfb_in_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output crcfb_pkg::crcfb_out_t  result
);
  import crcfb_pkg::*;

  crcfb_head_t head;
  logic        pop;

  crcfb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .valid (item_valid),
    .ready (item_ready),
    .item  (item),
    .head  (head),
    .pop   (pop)
  );

  crcfb_serializer u_ser (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .valid  (result_valid),
    .ready  (result_ready),
    .result (result)
  );

endmodule
